/* hw/rtl/lcbc_pkg.sv */
package lcbc_pkg;

  localparam int NUM_BUFS  = 8;
  localparam int CLUSTER_W = 28;
  localparam int SLOT_W    = $clog2(NUM_BUFS);
  localparam int CNT_W     = $clog2(NUM_BUFS + 1);
  localparam int LOCK_W    = 8;
  localparam int ACC_W     = 16;
  localparam int LIMIT_W   = 4;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(8);
  localparam logic [LOCK_W-1:0]  LOCK_MAX    = '1;
  localparam logic [ACC_W-1:0]   ACC_MAX     = '1;

  typedef enum logic {
    OP_LOCK   = 1'b0,
    OP_UNLOCK = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_IN_USE = 2'd1,
    ST_UNDERFLOW  = 2'd2
  } status_t;

  // One buffer's bookkeeping, held by the cell at its recency slot.
  typedef struct packed {
    logic [SLOT_W-1:0]    id;
    logic [CLUSTER_W-1:0] tag;
    logic                 dirty;
    logic [LOCK_W-1:0]    lock;
    logic [ACC_W-1:0]     acc;
  } entry_t;

  typedef struct packed {
    logic load;        // take the left neighbor's entry
    logic unlock;      // apply an unlock to the held entry
    logic mark_dirty;
    logic commit;
  } cell_ctl_t;

endpackage

/* hw/rtl/lcbc_cell.sv */
module lcbc_cell (
  input  logic                               clk,
  input  logic                               valid_i,
  input  lcbc_pkg::cell_ctl_t                ctl_i,
  input  lcbc_pkg::entry_t                   left_i,
  input  logic [lcbc_pkg::CLUSTER_W-1:0]     cluster_i,
  input  logic [lcbc_pkg::SLOT_W-1:0]        bid_i,
  output lcbc_pkg::entry_t                   entry_o,
  output logic                               tag_hit_o,
  output logic                               id_hit_o
);

  localparam int LW = lcbc_pkg::LOCK_W;

  lcbc_pkg::entry_t entry_r;
  lcbc_pkg::entry_t entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl_i.load) begin
      entry_nxt = left_i;
    end else if (ctl_i.unlock) begin
      if (entry_r.lock != '0) begin
        entry_nxt.lock = entry_r.lock - LW'(1);
      end
      entry_nxt.dirty = (entry_r.dirty | ctl_i.mark_dirty) & ~ctl_i.commit;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_o   = entry_r;
  assign tag_hit_o = valid_i && (entry_r.tag == cluster_i);
  assign id_hit_o  = valid_i && (entry_r.id == bid_i);

endmodule

/* hw/rtl/lru_cluster_buffer_cache.sv */
// Pipeline: an accepted in_ beat passes the request stage, then lookup/update into
//   the output register; the recency cells shift and compare in the same cycle.
// Throughput: 1 beat per cycle while out_tready holds.
// Reset (rst_n, sync, active low): no buffers in use, buffer_limit = 8, both stages
//   empty. Cell contents are not reset; only in-use slots are ever read.
module lru_cluster_buffer_cache (
  input  logic                              clk,
  input  logic                              rst_n,
  // Config: buffer_limit
  input  logic                              cfg_wr_en,
  input  logic [lcbc_pkg::LIMIT_W-1:0]      cfg_wr_data,
  // Request channel
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [27:0] cluster, [30:28] buffer_id, [31] mark_dirty, [32] commit, [39:33] zero
  input  logic [39:0]                       in_tdata,
  // [0] op
  input  logic                              in_tuser,
  // Result channel
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [2:0] granted_buffer, [3] hit, [4] fill_request, [5] writeback_request,
  // [33:6] writeback_cluster, [41:34] lock_count, [57:42] access_count,
  // [59:58] status, [63:60] zero
  output logic [63:0]                       out_tdata
);

  localparam int N  = lcbc_pkg::NUM_BUFS;
  localparam int SW = lcbc_pkg::SLOT_W;
  localparam int CW = lcbc_pkg::CNT_W;
  localparam int KW = lcbc_pkg::CLUSTER_W;
  localparam int LW = lcbc_pkg::LOCK_W;
  localparam int AW = lcbc_pkg::ACC_W;

  // ---------------------------------------------------------------------------
  // Config register
  // ---------------------------------------------------------------------------
  logic [lcbc_pkg::LIMIT_W-1:0] limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= lcbc_pkg::LIMIT_RESET;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  // Zero acts as one, anything above the buffer count as the buffer count.
  logic [CW-1:0] eff_limit;
  always_comb begin
    eff_limit = CW'(limit_r);
    if (limit_r == '0) begin
      eff_limit = CW'(1);
    end else if (CW'(limit_r) > CW'(N)) begin
      eff_limit = CW'(N);
    end
  end

  // ---------------------------------------------------------------------------
  // Request stage
  // ---------------------------------------------------------------------------
  logic                req_valid_r;
  lcbc_pkg::op_t       req_op_r;
  logic [KW-1:0]       req_cluster_r;
  logic [SW-1:0]       req_bid_r;
  logic                req_md_r;
  logic                req_cmt_r;
  logic                out_valid_r;
  logic                exec;

  // A staged request executes when the output register is free or draining.
  assign exec      = req_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !req_valid_r || exec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_tready) begin
      req_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      req_op_r      <= lcbc_pkg::op_t'(in_tuser);
      req_cluster_r <= in_tdata[KW-1:0];
      req_bid_r     <= in_tdata[30:28];
      req_md_r      <= in_tdata[31];
      req_cmt_r     <= in_tdata[32];
    end
  end

  // ---------------------------------------------------------------------------
  // Recency chain: slot 0 most recent, slots below in_use_r hold buffers.
  // Move-to-front shifts slots 1..p right by one and loads slot 0.
  // ---------------------------------------------------------------------------
  logic [CW-1:0]       in_use_r;
  lcbc_pkg::entry_t    cell_entry [N];
  logic [N-1:0]        tag_hit;
  logic [N-1:0]        id_hit;
  lcbc_pkg::entry_t    front;
  logic [SW-1:0]       shift_pos;
  logic                is_lock;
  logic                is_unlock;

  assign is_lock   = exec && (req_op_r == lcbc_pkg::OP_LOCK);
  assign is_unlock = exec && (req_op_r == lcbc_pkg::OP_UNLOCK);

  for (genvar k = 0; k < N; k++) begin : g_cell
    lcbc_pkg::cell_ctl_t ctl;
    lcbc_pkg::entry_t    left;

    assign ctl.load       = is_lock && (SW'(k) <= shift_pos);
    assign ctl.unlock     = is_unlock && id_hit[k];
    assign ctl.mark_dirty = req_md_r;
    assign ctl.commit     = req_cmt_r;

    if (k == 0) begin : g_head
      assign left = front;
    end else begin : g_body
      assign left = cell_entry[k-1];
    end

    lcbc_cell u_cell (
      .clk       (clk),
      .valid_i   (CW'(k) < in_use_r),
      .ctl_i     (ctl),
      .left_i    (left),
      .cluster_i (req_cluster_r),
      .bid_i     (req_bid_r),
      .entry_o   (cell_entry[k]),
      .tag_hit_o (tag_hit[k]),
      .id_hit_o  (id_hit[k])
    );
  end

  // ---------------------------------------------------------------------------
  // Lookup and result
  // ---------------------------------------------------------------------------
  logic [SW-1:0]       hit_pos;
  logic [SW-1:0]       id_pos;
  logic [SW-1:0]       last_pos;
  logic [SW-1:0]       rd_pos;
  logic                any_hit;
  logic                in_range;
  logic                alloc;
  lcbc_pkg::entry_t    sel;

  // Lowest matching slot wins (tags are unique, so at most one matches anyway).
  always_comb begin
    hit_pos = '0;
    id_pos  = '0;
    for (int k = N - 1; k >= 0; k--) begin
      if (tag_hit[k]) hit_pos = SW'(k);
      if (id_hit[k])  id_pos  = SW'(k);
    end
  end

  assign any_hit  = |tag_hit;
  assign in_range = |id_hit;
  assign last_pos = SW'(in_use_r - CW'(1));
  assign alloc    = !any_hit && (in_use_r < eff_limit);
  assign rd_pos   = (req_op_r == lcbc_pkg::OP_UNLOCK) ? id_pos :
                    (any_hit ? hit_pos : last_pos);
  assign sel      = cell_entry[rd_pos];

  // On allocate the free slot at in_use_r is the end of the shift.
  always_comb begin
    if (any_hit) begin
      shift_pos = hit_pos;
    end else if (alloc) begin
      shift_pos = SW'(in_use_r);
    end else begin
      shift_pos = last_pos;
    end
  end

  // New front entry for a lock: hit keeps the entry, a miss retags it.
  always_comb begin
    if (any_hit) begin
      front = sel;
    end else begin
      front.id    = alloc ? SW'(in_use_r) : sel.id;
      front.tag   = req_cluster_r;
      front.dirty = 1'b0;
      front.lock  = '0;
      front.acc   = '0;
    end
    if (front.lock != lcbc_pkg::LOCK_MAX) front.lock = front.lock + LW'(1);
    if (front.acc  != lcbc_pkg::ACC_MAX)  front.acc  = front.acc + AW'(1);
  end

  logic [SW-1:0]         res_granted;
  logic                  res_hit;
  logic                  res_fill;
  logic                  res_wb;
  logic [KW-1:0]         res_wbcl;
  logic [LW-1:0]         res_lock;
  logic [AW-1:0]         res_acc;
  lcbc_pkg::status_t     res_status;

  always_comb begin
    res_granted = req_bid_r;
    res_hit     = 1'b0;
    res_fill    = 1'b0;
    res_wb      = 1'b0;
    res_wbcl    = '0;
    res_lock    = '0;
    res_acc     = '0;
    res_status  = lcbc_pkg::ST_OK;
    if (req_op_r == lcbc_pkg::OP_LOCK) begin
      res_granted = front.id;
      res_hit     = any_hit;
      res_fill    = !any_hit;
      res_lock    = front.lock;
      res_acc     = front.acc;
      // Eviction of a dirty buffer writes its old cluster back.
      if (!any_hit && !alloc && sel.dirty) begin
        res_wb   = 1'b1;
        res_wbcl = sel.tag;
      end
    end else if (!in_range) begin
      res_status = lcbc_pkg::ST_NOT_IN_USE;
    end else begin
      res_acc = sel.acc;
      if (sel.lock == '0) begin
        res_status = lcbc_pkg::ST_UNDERFLOW;
      end else begin
        res_lock = sel.lock - LW'(1);
      end
      if (req_cmt_r) begin
        res_wb   = 1'b1;
        res_wbcl = sel.tag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= '0;
    end else if (is_lock && alloc) begin
      in_use_r <= in_use_r + CW'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic [63:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      out_data_r <= {4'b0, res_status, res_acc, res_lock, res_wbcl,
                     res_wb, res_fill, res_hit, res_granted};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_in_use_bound: assert property (@(posedge clk) disable iff (!rst_n)
    in_use_r <= CW'(N))
    else $error("buffers in use above buffer count");

  a_tag_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tag_hit))
    else $error("cluster cached in more than one buffer");

  a_id_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(id_hit))
    else $error("buffer id held by more than one slot");

  a_alloc_count: assert property (@(posedge clk) disable iff (!rst_n)
    (is_lock && alloc) |=> (in_use_r == $past(in_use_r) + CW'(1)))
    else $error("allocation did not advance buffers in use");

  a_front_after_lock: assert property (@(posedge clk) disable iff (!rst_n)
    is_lock |=> (cell_entry[0].id == out_data_r[SW-1:0]))
    else $error("granted buffer not at most recent slot");

endmodule

/* bench/tb_lru_cluster_buffer_cache.sv */
module tb_lru_cluster_buffer_cache;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles with no beat on either side before the run is declared hung.
  // Slowest legal wait is the long receiver hold in test_backpressure plus a send gap.
  localparam int STALL_LIMIT = 4000;

  // ---------------------------------------------------------------------------
  // Clock, reset, DUT ports
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  always #1 clk = ~clk;

  logic                           rst_n       = 1'b0;
  logic                           cfg_wr_en   = 1'b0;
  logic [lcbc_pkg::LIMIT_W-1:0]   cfg_wr_data = '0;
  logic                           in_tvalid   = 1'b0;
  logic                           in_tready;
  logic [39:0]                    in_tdata    = '0;  // [27:0] cluster, [30:28] buffer_id,
                                                     // [31] mark_dirty, [32] commit
  logic                           in_tuser    = 1'b0;  // [0] op
  logic                           out_tvalid;
  logic                           out_tready  = 1'b0;
  logic [63:0]                    out_tdata;  // [2:0] granted_buffer, [3] hit,
                                              // [4] fill_request, [5] writeback_request,
                                              // [33:6] writeback_cluster,
                                              // [41:34] lock_count, [57:42] access_count,
                                              // [59:58] status

  lru_cluster_buffer_cache u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  // ---------------------------------------------------------------------------
  // Cache shadow: the bookkeeping the block should hold after each beat
  // ---------------------------------------------------------------------------
  typedef struct {
    logic [lcbc_pkg::SLOT_W-1:0]    buf_id;
    logic                           hit;
    logic                           fill;
    logic                           wb;
    logic [lcbc_pkg::CLUSTER_W-1:0] wb_cluster;
    logic [lcbc_pkg::LOCK_W-1:0]    locks;
    logic [lcbc_pkg::ACC_W-1:0]     accesses;
    lcbc_pkg::status_t              status;
  } reply_t;

  logic [lcbc_pkg::CLUSTER_W-1:0] tag_of   [lcbc_pkg::NUM_BUFS] = '{default: '0};
  logic                           dirty_of [lcbc_pkg::NUM_BUFS] = '{default: 1'b0};
  logic [lcbc_pkg::LOCK_W-1:0]    locks_of [lcbc_pkg::NUM_BUFS] = '{default: '0};
  logic [lcbc_pkg::ACC_W-1:0]     acc_of   [lcbc_pkg::NUM_BUFS] = '{default: '0};
  int                             mru_order[lcbc_pkg::NUM_BUFS] = '{default: 0};  // slot 0 = MRU
  int                             bufs_taken = 0;
  logic [lcbc_pkg::LIMIT_W-1:0]   limit_reg  = lcbc_pkg::LIMIT_RESET;

  reply_t replies_due[$];  // one per accepted request, oldest first

  // Stimulus knobs shared with the side processes
  bit tx_idle_en     = 1'b1;
  bit rx_stall_en    = 1'b1;
  int rx_hold_cycles = 0;

  int mismatch_count = 0;
  int quiet_cycles   = 0;

  logic [lcbc_pkg::CLUSTER_W-1:0] cluster_pool[16];
  int                             pool_size = 1;
  int                             held_bufs[$];  // buffers granted and not yet unlocked

  // Move recency slot pos to the front, shifting the newer ones back.
  function automatic void to_front(int pos);
    int id;
    id = mru_order[pos];
    for (int p = pos; p > 0; p--) mru_order[p] = mru_order[p - 1];
    mru_order[0] = id;
  endfunction

  function automatic reply_t predict_reply(lcbc_pkg::op_t op,
                                           logic [lcbc_pkg::CLUSTER_W-1:0] cl,
                                           logic [lcbc_pkg::SLOT_W-1:0] bid,
                                           logic md, logic cmt);
    reply_t r;
    int     pos;
    int     lim;
    int     id;
    bit     found;
    r.buf_id = '0; r.hit = 1'b0; r.fill = 1'b0; r.wb = 1'b0;
    r.wb_cluster = '0; r.locks = '0; r.accesses = '0; r.status = lcbc_pkg::ST_OK;
    if (op == lcbc_pkg::OP_LOCK) begin
      found = 1'b0;
      pos   = 0;
      for (int p = 0; p < bufs_taken; p++) begin
        if (!found && tag_of[mru_order[p]] == cl) begin
          found = 1'b1;
          pos   = p;
        end
      end
      if (found) begin
        to_front(pos);
        r.hit = 1'b1;
      end else begin
        // limit 0 behaves as 1, anything past the pool size as the pool size
        lim = int'(limit_reg);
        if (lim == 0) lim = 1;
        if (lim > lcbc_pkg::NUM_BUFS) lim = lcbc_pkg::NUM_BUFS;
        if (bufs_taken < lim) begin
          id = bufs_taken;
          mru_order[bufs_taken] = id;
          to_front(bufs_taken);
          bufs_taken++;
        end else begin
          // evict LRU regardless of its lock count
          id = mru_order[bufs_taken - 1];
          if (dirty_of[id]) begin
            r.wb         = 1'b1;
            r.wb_cluster = tag_of[id];
          end
          to_front(bufs_taken - 1);
        end
        acc_of[id]   = '0;
        locks_of[id] = '0;
        dirty_of[id] = 1'b0;
        tag_of[id]   = cl;
        r.fill       = 1'b1;
      end
      id = mru_order[0];
      if (acc_of[id] != lcbc_pkg::ACC_MAX) acc_of[id]++;
      if (locks_of[id] != lcbc_pkg::LOCK_MAX) locks_of[id]++;
      r.buf_id   = lcbc_pkg::SLOT_W'(id);
      r.locks    = locks_of[id];
      r.accesses = acc_of[id];
    end else begin
      r.buf_id = bid;
      if (int'(bid) >= bufs_taken) begin
        r.status = lcbc_pkg::ST_NOT_IN_USE;  // nothing touched, all other fields zero
      end else begin
        if (locks_of[bid] == '0) r.status = lcbc_pkg::ST_UNDERFLOW;
        else locks_of[bid]--;
        if (md) dirty_of[bid] = 1'b1;
        if (cmt) begin
          r.wb          = 1'b1;
          r.wb_cluster  = tag_of[bid];
          dirty_of[bid] = 1'b0;
        end
        r.locks    = locks_of[bid];
        r.accesses = acc_of[bid];
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  // Mostly back-to-back, some short gaps, the odd long one.
  function automatic int pick_gap();
    int r;
    if (!tx_idle_en) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one request beat and hold it until taken. tvalid is left high so
  // the next call can go back-to-back; finish_phase drops it.
  task automatic send_req(lcbc_pkg::op_t op, logic [lcbc_pkg::CLUSTER_W-1:0] cl,
                          logic [lcbc_pkg::SLOT_W-1:0] bid, logic md, logic cmt);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {7'b0, cmt, md, bid, cl};
    do @(posedge clk); while (!in_tready);
    replies_due.push_back(predict_reply(op, cl, bid, md, cmt));
  endtask

  // Stop offering and wait until every reply has come back.
  task automatic finish_phase();
    in_tvalid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  // Only called with the block idle.
  task automatic write_limit(logic [lcbc_pkg::LIMIT_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    limit_reg = v;
  endtask

  // Lock/unlock traffic: locks mostly from a small cluster pool so hits and
  // evictions both show up, unlocks mostly of buffers we were granted.
  task automatic random_request();
    int                             r;
    logic [lcbc_pkg::CLUSTER_W-1:0] cl;
    logic [lcbc_pkg::SLOT_W-1:0]    b;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      if (r < 6) cl = lcbc_pkg::CLUSTER_W'($urandom);
      else cl = cluster_pool[$urandom_range(0, pool_size - 1)];
      send_req(lcbc_pkg::OP_LOCK, cl, lcbc_pkg::SLOT_W'($urandom), 1'($urandom),
               1'($urandom));
      held_bufs.push_back(mru_order[0]);
      if (held_bufs.size() > 16) void'(held_bufs.pop_front());
    end else begin
      if (held_bufs.size() != 0 && r < 90) b = lcbc_pkg::SLOT_W'(held_bufs.pop_front());
      else b = lcbc_pkg::SLOT_W'($urandom_range(0, lcbc_pkg::NUM_BUFS - 1));
      send_req(lcbc_pkg::OP_UNLOCK, lcbc_pkg::CLUSTER_W'($urandom), b, 1'($urandom),
               ($urandom_range(0, 3) == 0));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: ready pattern, checker, watchdog
  // ---------------------------------------------------------------------------
  initial begin : rx_ready_drive
    int stall_left;
    int n;
    int r;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rx_hold_cycles > 0) begin
        // long hold-off, counted here so the sender keeps pushing meanwhile
        n = rx_hold_cycles;
        rx_hold_cycles = 0;
        out_tready <= 1'b0;
        for (int i = 0; i < n; i++) @(posedge clk);
      end else if (!rx_stall_en) begin
        out_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 75) begin
          out_tready <= 1'b1;
        end else if (r < 95) begin
          stall_left = $urandom_range(0, 2);
          out_tready <= 1'b0;
        end else begin
          stall_left = $urandom_range(10, 30);
          out_tready <= 1'b0;
        end
      end
    end
  end

  task automatic note_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] %s: got %0h, want %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : reply_check
    reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (replies_due.size() == 0) begin
        note_mismatch("beat with nothing pending", out_tdata, '0);
      end else begin
        want = replies_due.pop_front();
        if (out_tdata[2:0] !== want.buf_id)
          note_mismatch("granted_buffer", 64'(out_tdata[2:0]), 64'(want.buf_id));
        if (out_tdata[3] !== want.hit)
          note_mismatch("hit", 64'(out_tdata[3]), 64'(want.hit));
        if (out_tdata[4] !== want.fill)
          note_mismatch("fill_request", 64'(out_tdata[4]), 64'(want.fill));
        if (out_tdata[5] !== want.wb)
          note_mismatch("writeback_request", 64'(out_tdata[5]), 64'(want.wb));
        if (out_tdata[33:6] !== want.wb_cluster)
          note_mismatch("writeback_cluster", 64'(out_tdata[33:6]), 64'(want.wb_cluster));
        if (out_tdata[41:34] !== want.locks)
          note_mismatch("lock_count", 64'(out_tdata[41:34]), 64'(want.locks));
        if (out_tdata[57:42] !== want.accesses)
          note_mismatch("access_count", 64'(out_tdata[57:42]), 64'(want.accesses));
        if (out_tdata[59:58] !== want.status)
          note_mismatch("status", 64'(out_tdata[59:58]), 64'(want.status));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("lru_cluster_buffer_cache verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Fresh from reset with a limit of 0 (acts as 1): unlocks of untaken buffers,
  // then every miss recycles buffer 0, including a dirty write-back; then limits 1 and 3.
  task automatic test_small_limits();
    write_limit(4'd0);
    send_req(lcbc_pkg::OP_UNLOCK, '1, 3'd7, 1'b1, 1'b1);
    send_req(lcbc_pkg::OP_UNLOCK, '0, 3'd0, 1'b0, 1'b0);
    send_req(lcbc_pkg::OP_LOCK, 28'h0000001, 3'd0, 1'b0, 1'b0);
    send_req(lcbc_pkg::OP_LOCK, 28'h0000001, 3'd7, 1'b1, 1'b1);  // hit
    send_req(lcbc_pkg::OP_LOCK, 28'h0000002, 3'd0, 1'b0, 1'b0);  // clean evict
    send_req(lcbc_pkg::OP_UNLOCK, 28'h0, 3'd0, 1'b1, 1'b0);      // mark dirty
    send_req(lcbc_pkg::OP_LOCK, 28'h0000003, 3'd0, 1'b0, 1'b0);  // dirty evict
    finish_phase();
    write_limit(4'd1);
    send_req(lcbc_pkg::OP_LOCK, 28'h0000004, 3'd0, 1'b0, 1'b0);
    finish_phase();
    write_limit(4'd3);
    send_req(lcbc_pkg::OP_LOCK, 28'h0000005, 3'd0, 1'b0, 1'b0);
    send_req(lcbc_pkg::OP_LOCK, 28'h0000006, 3'd0, 1'b0, 1'b0);
    send_req(lcbc_pkg::OP_LOCK, 28'h0000007, 3'd0, 1'b0, 1'b0);  // evicts within 3
    finish_phase();
  endtask

  // Limit past the pool size: fill all buffers, cluster extremes, dirty
  // eviction, underflow, commit with and without a lock held.
  task automatic test_directed_ops();
    write_limit(4'd15);
    send_req(lcbc_pkg::OP_LOCK, 28'h0000000, 3'd0, 1'b0, 1'b0);
    send_req(lcbc_pkg::OP_LOCK, 28'hFFFFFFF, 3'd7, 1'b1, 1'b1);
    for (int i = 0; i < 3; i++)
      send_req(lcbc_pkg::OP_LOCK, lcbc_pkg::CLUSTER_W'(28'h0A00000 + i), 3'd0, 1'b0, 1'b0);
    send_req(lcbc_pkg::OP_LOCK, 28'h0000000, 3'd0, 1'b0, 1'b0);  // hit
    send_req(lcbc_pkg::OP_UNLOCK, 28'h0, 3'd4, 1'b1, 1'b0);      // all-ones buffer dirty
    send_req(lcbc_pkg::OP_UNLOCK, 28'h0, 3'd4, 1'b0, 1'b0);      // underflow
    // fresh misses walk the LRU end until the dirty one is written back
    for (int i = 0; i < lcbc_pkg::NUM_BUFS; i++)
      send_req(lcbc_pkg::OP_LOCK, lcbc_pkg::CLUSTER_W'(28'h5A50000 + i), 3'd0, 1'b0, 1'b0);
    send_req(lcbc_pkg::OP_UNLOCK, 28'h0, lcbc_pkg::SLOT_W'(mru_order[0]), 1'b1, 1'b1);
    send_req(lcbc_pkg::OP_UNLOCK, 28'h0, lcbc_pkg::SLOT_W'(mru_order[0]), 1'b1,
             1'b1);  // underflow + commit
    finish_phase();
  endtask

  // Limit dropped under the buffers in use: nothing freed, misses evict LRU.
  task automatic test_limit_below_use();
    write_limit(4'd2);
    send_req(lcbc_pkg::OP_LOCK, tag_of[mru_order[lcbc_pkg::NUM_BUFS - 1]], 3'd0, 1'b0,
             1'b0);
    for (int i = 0; i < 3; i++)
      send_req(lcbc_pkg::OP_LOCK, lcbc_pkg::CLUSTER_W'(28'h0C00000 + i), 3'd0, 1'b0, 1'b0);
    finish_phase();
  endtask

  // One cluster hammered past the lock count ceiling, then unlocked.
  task automatic test_count_saturation();
    write_limit(4'd8);
    tx_idle_en  = 1'b0;
    rx_stall_en = 1'b0;
    for (int i = 0; i < int'(lcbc_pkg::LOCK_MAX) + 4; i++)
      send_req(lcbc_pkg::OP_LOCK, 28'h3C3C3C3, lcbc_pkg::SLOT_W'($urandom), 1'($urandom),
               1'($urandom));
    send_req(lcbc_pkg::OP_UNLOCK, 28'h0, lcbc_pkg::SLOT_W'(mru_order[0]), 1'b1, 1'b0);
    send_req(lcbc_pkg::OP_UNLOCK, 28'h0, lcbc_pkg::SLOT_W'(mru_order[0]), 1'b0, 1'b1);
    finish_phase();
    tx_idle_en  = 1'b1;
    rx_stall_en = 1'b1;
  endtask

  task automatic test_random_traffic();
    logic [lcbc_pkg::LIMIT_W-1:0] limits[7];
    limits = '{4'd8, 4'd0, 4'd15, 4'd2, 4'd1, lcbc_pkg::LIMIT_W'($urandom),
               lcbc_pkg::LIMIT_W'($urandom)};
    for (int ph = 0; ph < 7; ph++) begin
      write_limit(limits[ph]);
      pool_size = $urandom_range(3, 12);
      for (int i = 0; i < 16; i++) cluster_pool[i] = lcbc_pkg::CLUSTER_W'($urandom);
      // one phase with no send gaps, another with the receiver always ready
      tx_idle_en  = (ph != 1);
      rx_stall_en = (ph != 2);
      repeat (50) random_request();
      finish_phase();
    end
    tx_idle_en  = 1'b1;
    rx_stall_en = 1'b1;
  endtask

  // Receiver goes quiet for a long stretch while the sender keeps offering,
  // so the pipeline fills and in_tready has to drop.
  task automatic test_backpressure();
    tx_idle_en     = 1'b0;
    rx_hold_cycles = 300;
    repeat (60) random_request();
    finish_phase();
    tx_idle_en = 1'b1;
  endtask

  initial begin : run
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_small_limits();
    test_directed_ops();
    test_limit_below_use();
    test_count_saturation();
    test_random_traffic();
    test_backpressure();
    // let the two-stage pipe settle in case a stray beat is still coming
    repeat (6) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("lru_cluster_buffer_cache verification clean");
    end else begin
      $display("lru_cluster_buffer_cache verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/lcbc_pkg.sv
hw/rtl/lcbc_cell.sv
hw/rtl/lru_cluster_buffer_cache.sv
bench/tb_lru_cluster_buffer_cache.sv
